// File: rtl/chrup_pkg.sv
// Shared types and constants of the 2x triangle chroma upsampler.
// Holds register codes, configuration and queue entry types.
// No dependencies; all RTL modules but the checker import it.
`timescale 1ns / 1ps
`default_nettype none

package chrup_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;
   localparam int FIFO_DEPTH         = 4;

   localparam int SAMPLE_W = 16;
   localparam int VVAL_W   = 18;
   localparam int OUT_W    = 20;
   localparam int COORD_W  = 12;
   localparam int SIZE_W   = 12;

   // Register indexes, word addressed on the configuration port.
   localparam logic [1:0] REG_ENABLE_VERTICAL   = 2'd0;
   localparam logic [1:0] REG_ENABLE_HORIZONTAL = 2'd1;
   localparam logic [1:0] REG_SOURCE_WIDTH      = 2'd2;
   localparam logic [1:0] REG_SOURCE_HEIGHT     = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 12'h800;

   typedef logic signed [VVAL_W-1:0] vval_type;

   typedef struct packed {
      logic              enable_vertical;
      logic              enable_horizontal;
      logic [SIZE_W-1:0] source_width;
      logic [SIZE_W-1:0] source_height;
   } cfg_type;

   // One classified input item, waiting for the horizontal pass.
   typedef struct packed {
      vval_type [2:0]     vval;
      logic [2:0][COORD_W-1:0] vrow;
      logic               vok1;
      logic               vok2;
      logic [COORD_W-1:0] col_low;
      logic               col_zero;
      logic               last_col;
      logic               last_row;
      logic               en_h;
      logic [1:0]         nh;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/chroma_upsample_2x_triangle.sv
// 2x triangle-filter chroma upsampler, top level.
// Depends on chrup_pkg, chrup_csr, chrup_front, chrup_fifo and chrup_back.
//
// Source samples (Q12.4) enter on req_* in raster order, one per item.
// Each item yields one to nine output samples (Q12.8) on rsp_*, with
// their output column and row, tlast on the last result of the item and
// tuser[0] on the final sample of the output plane. Registers on csr_*
// set the enabled axes and the source size; write them only while idle.
// An accepted item passes the stage register, the queue and the work
// register before its first result reaches the result register, which
// issues one result per cycle while the receiver is ready. An item
// yields about four results with both axes doubled. Items go through
// a four-entry queue, so the input keeps flowing while results drain.
// When the receiver stalls, the result register holds and the queue
// fills; after that req_tready drops until space frees up.
// Reset clears the position counters, the left-neighbor values and the
// queue, and loads the registers with both axes on and a 2048 x 2048
// plane. The line store is not cleared: its reads in the first row go unused.
`timescale 1ns / 1ps
`default_nettype none

module chroma_upsample_2x_triangle import chrup_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [15:0] sample_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,    // [19:0] sample_out, [31:20] out_column,
                                          // [43:32] out_row, [47:44] zero
   output logic             rsp_tlast,    // run_last
   output logic [0:0]       rsp_tuser,    // [0] plane_done
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type            cfg;
   logic               push, fifo_full, pop, fifo_empty;
   entry_type          push_entry, head;
   logic [OUT_W-1:0]   rsp_sample;
   logic [COORD_W-1:0] rsp_column, rsp_row;
   logic               rsp_plane_done;

   chrup_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   chrup_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_tdata),
      .push       (push),
      .push_entry (push_entry),
      .fifo_full  (fifo_full)
   );

   chrup_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (pop),
      .head       (head),
      .empty      (fifo_empty)
   );

   chrup_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (fifo_empty),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_sample     (rsp_sample),
      .rsp_column     (rsp_column),
      .rsp_row        (rsp_row),
      .rsp_run_last   (rsp_tlast),
      .rsp_plane_done (rsp_plane_done)
   );

   assign rsp_tdata    = {4'd0, rsp_row, rsp_column, rsp_sample};
   assign rsp_tuser[0] = rsp_plane_done;

endmodule

`default_nettype wire

// File: rtl/chrup_csr.sv
// Configuration register file of the chroma upsampler.
// APB-style write and read; depends on chrup_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chrup_csr import chrup_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_ENABLE_VERTICAL:   cfg_in.enable_vertical   = csr_pwdata[0];
            REG_ENABLE_HORIZONTAL: cfg_in.enable_horizontal = csr_pwdata[0];
            REG_SOURCE_WIDTH:      cfg_in.source_width      = csr_pwdata[SIZE_W-1:0];
            REG_SOURCE_HEIGHT:     cfg_in.source_height     = csr_pwdata[SIZE_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ENABLE_VERTICAL:   csr_prdata = {31'd0, cfg_ff.enable_vertical};
         REG_ENABLE_HORIZONTAL: csr_prdata = {31'd0, cfg_ff.enable_horizontal};
         REG_SOURCE_WIDTH:      csr_prdata = {20'd0, cfg_ff.source_width};
         REG_SOURCE_HEIGHT:     csr_prdata = {20'd0, cfg_ff.source_height};
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_vertical   <= 1'b1;
         cfg_ff.enable_horizontal <= 1'b1;
         cfg_ff.source_width      <= SIZE_RESET;
         cfg_ff.source_height     <= SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/chrup_front.sv
// Front end: accepts source items, tracks position, reads the line store
// and forms the vertical values of each item. Depends on chrup_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chrup_front import chrup_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   output logic                     push,
   output entry_type                push_entry,
   input  wire logic                fifo_full
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int XW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
   localparam int YW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic                a_valid_ff, a_valid_in;
   entry_type           a_entry_ff, new_entry;
   logic [SAMPLE_W-1:0] a_sample_ff;
   logic                a_en_v_ff;
   logic                a_row_zero_ff;
   logic [SAMPLE_W-1:0] rd_ff;
   logic [SAMPLE_W-1:0] line_mem [MAX_WIDTH];

   logic                accept;
   logic [SIZE_W-1:0]   w_eff, h_eff;
   logic [XW-1:0]       c_next;
   logic [YW-1:0]       r_next;
   logic                last_col, last_row;
   logic [COORD_W-1:0]  r_low;
   logic [COORD_W-1:0]  r_twice;

   logic signed [SAMPLE_W-1:0] s, p;
   logic signed [VVAL_W-1:0]   s_x, p_x;

   assign req_tready = !a_valid_ff || !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = a_valid_ff && !fifo_full;

   // Zero sizes count as one; the upper clamp is the second compare.
   assign w_eff    = (cfg.source_width == '0) ? SIZE_W'(1) : cfg.source_width;
   assign h_eff    = (cfg.source_height == '0) ? SIZE_W'(1) : cfg.source_height;
   assign c_next   = XW'(col_ff) + XW'(1);
   assign r_next   = YW'(row_ff) + YW'(1);
   assign last_col = (c_next >= XW'(w_eff)) || (c_next >= XW'(MAX_WIDTH));
   assign last_row = (r_next >= YW'(h_eff)) || (r_next >= YW'(MAX_HEIGHT));
   assign r_low    = COORD_W'(row_ff);
   assign r_twice  = {r_low[COORD_W-2:0], 1'b0};

   always_comb begin
      new_entry          = '0;
      new_entry.col_low  = COORD_W'(col_ff);
      new_entry.col_zero = (col_ff == '0);
      new_entry.last_col = last_col;
      new_entry.last_row = last_row;
      new_entry.en_h     = cfg.enable_horizontal;
      if (!cfg.enable_horizontal) begin
         new_entry.nh = 2'd1;
      end else begin
         new_entry.nh = ((col_ff == '0) ? 2'd1 : 2'd2) + {1'b0, last_col};
      end
      if (cfg.enable_vertical) begin
         new_entry.vok1    = (row_ff != '0);
         new_entry.vok2    = last_row;
         new_entry.vrow[0] = (row_ff == '0) ? '0 : r_twice - COORD_W'(1);
         new_entry.vrow[1] = r_twice;
         new_entry.vrow[2] = r_twice | COORD_W'(1);
      end else begin
         new_entry.vrow[0] = r_low;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : RW'(r_next);
         end else begin
            col_in = CW'(c_next);
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (push) begin
         a_valid_in = 1'b0;
      end
   end

   // Vertical filter on the item held in the stage register.
   assign s   = $signed(a_sample_ff);
   assign p   = $signed(rd_ff);
   assign s_x = VVAL_W'(s);
   assign p_x = VVAL_W'(p);

   always_comb begin
      push_entry = a_entry_ff;
      push_entry.vval[0] = s_x <<< 2;
      push_entry.vval[1] = '0;
      push_entry.vval[2] = s_x <<< 2;
      if (a_en_v_ff && !a_row_zero_ff) begin
         push_entry.vval[0] = (p_x <<< 1) + p_x + s_x;
         push_entry.vval[1] = (s_x <<< 1) + s_x + p_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_entry_ff    <= new_entry;
         a_sample_ff   <= req_sample;
         a_en_v_ff     <= cfg.enable_vertical;
         a_row_zero_ff <= (row_ff == '0);
      end
   end

   // Line store: the old sample of this column is read as the new one is written.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff            <= line_mem[col_ff];
         line_mem[col_ff] <= req_sample;
      end
   end

endmodule

`default_nettype wire

// File: rtl/chrup_fifo.sv
// Short item queue between the front end and the horizontal back end.
// Depends on chrup_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module chrup_fifo import chrup_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output entry_type      head,
   output logic           empty
);

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int NW = $clog2(FIFO_DEPTH + 1);

   entry_type     store_ff [FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign full  = (count_ff == NW'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/chrup_back.sv
// Back end: walks the vertical rows of each queued item, applies the
// horizontal filter and drives the result register. Depends on chrup_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chrup_back import chrup_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire entry_type     head,
   input  wire logic          empty,
   output logic               pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [OUT_W-1:0]   rsp_sample,
   output logic [COORD_W-1:0] rsp_column,
   output logic [COORD_W-1:0] rsp_row,
   output logic               rsp_run_last,
   output logic               rsp_plane_done
);

   entry_type          w_entry_ff;
   logic               w_valid_ff, w_valid_in;
   logic [1:0]         k_ff, k_in;
   logic [1:0]         j_ff, j_in;
   vval_type           cur_left_ff [3];
   vval_type           left_ff     [3];

   logic               o_valid_ff, o_valid_in;
   logic [OUT_W-1:0]   o_sample_ff;
   logic [COORD_W-1:0] o_col_ff, o_row_ff;
   logic               o_last_ff, o_done_ff;

   logic               adv, emit, load;
   logic               slot_last, has_next, entry_last;
   logic [1:0]         k_next;
   logic signed [OUT_W-1:0] v, l, val;
   logic [COORD_W-1:0] col, col_twice;

   assign adv  = !o_valid_ff || rsp_tready;
   assign emit = w_valid_ff && adv;

   always_comb begin
      has_next = 1'b0;
      k_next   = 2'd0;
      case (k_ff)
         2'd0: begin
            has_next = w_entry_ff.vok1 || w_entry_ff.vok2;
            k_next   = w_entry_ff.vok1 ? 2'd1 : 2'd2;
         end
         2'd1: begin
            has_next = w_entry_ff.vok2;
            k_next   = 2'd2;
         end
         default: begin
            has_next = 1'b0;
            k_next   = 2'd0;
         end
      endcase
   end

   assign slot_last  = (j_ff == w_entry_ff.nh - 2'd1);
   assign entry_last = slot_last && !has_next;
   assign load       = !empty && (!w_valid_ff || (emit && entry_last));
   assign pop        = load;

   // Horizontal filter for output j of vertical row k.
   assign v         = OUT_W'($signed(w_entry_ff.vval[k_ff]));
   assign l         = OUT_W'($signed(cur_left_ff[k_ff]));
   assign col_twice = {w_entry_ff.col_low[COORD_W-2:0], 1'b0};

   always_comb begin
      if (!w_entry_ff.en_h) begin
         val = v <<< 2;
         col = w_entry_ff.col_low;
      end else if (w_entry_ff.col_zero && j_ff == 2'd0) begin
         val = v <<< 2;
         col = '0;
      end else if (j_ff == 2'd0) begin
         val = (l <<< 1) + l + v;
         col = col_twice - COORD_W'(1);
      end else if (j_ff == 2'd1 && !w_entry_ff.col_zero) begin
         val = (v <<< 1) + v + l;
         col = col_twice;
      end else begin
         // Right edge: a copy of the last column.
         val = v <<< 2;
         col = col_twice | COORD_W'(1);
      end
   end

   always_comb begin
      w_valid_in = w_valid_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      if (load) begin
         w_valid_in = 1'b1;
         k_in       = 2'd0;
         j_in       = 2'd0;
      end else if (emit) begin
         if (entry_last) begin
            w_valid_in = 1'b0;
         end else if (slot_last) begin
            k_in = k_next;
            j_in = 2'd0;
         end else begin
            j_in = j_ff + 2'd1;
         end
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      if (emit) begin
         o_valid_in = 1'b1;
      end else if (rsp_tready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         k_ff       <= 2'd0;
         j_ff       <= 2'd0;
         left_ff[0] <= '0;
         left_ff[1] <= '0;
         left_ff[2] <= '0;
      end else begin
         w_valid_ff <= w_valid_in;
         o_valid_ff <= o_valid_in;
         k_ff       <= k_in;
         j_ff       <= j_in;
         // The left values advance as each item is taken from the queue.
         if (load) begin
            left_ff[0] <= head.vval[0];
            if (head.vok1) begin
               left_ff[1] <= head.vval[1];
            end
            if (head.vok2) begin
               left_ff[2] <= head.vval[2];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         w_entry_ff     <= head;
         cur_left_ff[0] <= left_ff[0];
         cur_left_ff[1] <= left_ff[1];
         cur_left_ff[2] <= left_ff[2];
      end
      if (emit) begin
         o_sample_ff <= val;
         o_col_ff    <= col;
         o_row_ff    <= w_entry_ff.vrow[k_ff];
         o_last_ff   <= entry_last;
         o_done_ff   <= entry_last && w_entry_ff.last_col && w_entry_ff.last_row;
      end
   end

   assign rsp_tvalid     = o_valid_ff;
   assign rsp_sample     = o_sample_ff;
   assign rsp_column     = o_col_ff;
   assign rsp_row        = o_row_ff;
   assign rsp_run_last   = o_last_ff;
   assign rsp_plane_done = o_done_ff;

endmodule

`default_nettype wire

// File: rtl/chrup_checker.sv
// Port-level checks for the chroma upsampler, bound to its top level.
// Depends on chroma_upsample_2x_triangle's port list only.
`timescale 1ns / 1ps
`default_nettype none

module chrup_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [0:0]  rsp_tuser
);

   // A stalled result keeps its payload and flags.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The end of the plane is always the last result of its item.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("plane end without item end");

   // Reset empties the result register.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind chroma_upsample_2x_triangle chrup_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
